[hdl/assert_macros.svh]
// assertion helpers used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge of aclk outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// condition that must never be true outside reset
`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_CLK(label, !(cond), msg)

`endif

[hdl/lla_pkg.sv]
// ---------------------------------------------------------------------------
// lla_pkg
// shared widths, register indexes, reset values and types of the light
// level moving average block
// ---------------------------------------------------------------------------
package lla_pkg;

    localparam int SAMPLE_W = 12;
    localparam int LEVEL_W  = 7;
    localparam int THR_W    = 7;

    // full scale of the level
    localparam int LEVEL_MAX = 100;

    // quotient steps of the front end serial divider (quotient never exceeds 100)
    localparam int DIV_STEPS = LEVEL_W;

    localparam int RING_DEPTH_DEFAULT = 16;
    localparam int QUEUE_DEPTH        = 2;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANGE_THRESHOLD = 2'd2;

    localparam logic [SAMPLE_W-1:0] LOW_LIMIT_RESET        = 12'd0;
    localparam logic [SAMPLE_W-1:0] HIGH_LIMIT_RESET       = 12'd4095;
    localparam logic [THR_W-1:0]    CHANGE_THRESHOLD_RESET = 7'd5;

    typedef struct packed {
        logic [SAMPLE_W-1:0] low_limit;
        logic [SAMPLE_W-1:0] high_limit;
        logic [THR_W-1:0]    change_threshold;
    } lla_cfg_t;

    // status of the level queue: full to the front end, empty to the back end
    typedef struct packed {
        logic full;
        logic empty;
    } lla_q_status_t;

endpackage

[hdl/light_level_moving_average.sv]
// ---------------------------------------------------------------------------
// light_level_moving_average
// clamps, rescales light samples to 0..100, keeps a ring of levels, reports
// the ring mean at first and when a level strays past the change threshold
// ---------------------------------------------------------------------------
// The front end takes no new sample until it is idle again: it captures
// the sample, scales it by 100, runs the restoring divide by the span (none
// for an empty span) and hands the level over to a 2-entry level queue. The
// back end fetches a level, updates the ring and sum and, for a level that
// causes a report, takes the mean and waits for the output handshake; the
// mean is the running sum times the reciprocal of the ring depth. A result
// held at the output backs up the queue and then the front end. The ring
// needs no clearing pass: slots not yet written since reset read as zero.
`include "assert_macros.svh"

module light_level_moving_average
    import lla_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [SAMPLE_W-1:0]   s_raw_sample,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [LEVEL_W-1:0]    m_light_level
);

    lla_cfg_t      cfg_reg;
    lla_q_status_t q_status;
    logic          push_valid;
    logic [LEVEL_W-1:0] push_level;
    logic          pop;
    logic [LEVEL_W-1:0] pop_level;

    // configuration registers, unknown indexes ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.low_limit        <= LOW_LIMIT_RESET;
            cfg_reg.high_limit       <= HIGH_LIMIT_RESET;
            cfg_reg.change_threshold <= CHANGE_THRESHOLD_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_LOW_LIMIT:        cfg_reg.low_limit        <= cfg_data[SAMPLE_W-1:0];
                REG_HIGH_LIMIT:       cfg_reg.high_limit       <= cfg_data[SAMPLE_W-1:0];
                REG_CHANGE_THRESHOLD: cfg_reg.change_threshold <= cfg_data[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    lla_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_raw_sample (s_raw_sample),
        .push_valid   (push_valid),
        .push_level   (push_level),
        .q_status     (q_status)
    );

    lla_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push_valid),
        .push_level (push_level),
        .pop        (pop),
        .pop_level  (pop_level),
        .status     (q_status)
    );

    lla_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .q_status      (q_status),
        .pop_level     (pop_level),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_light_level (m_light_level)
    );

    // checks
    `ASSERT_CLK(a_level_range, m_valid |-> (m_light_level <= LEVEL_W'(LEVEL_MAX)), "average above full scale")
    `ASSERT_CLK(a_front_busy, (s_valid && s_ready) |=> !s_ready, "front took a request while busy")
    `ASSERT_NEVER(a_queue_empty_full, q_status.full && q_status.empty, "queue both full and empty")
    `ASSERT_CLK(a_push_level_range, push_valid |-> (push_level <= LEVEL_W'(LEVEL_MAX)), "scaled level above full scale")

endmodule

[hdl/lla_front.sv]
// ---------------------------------------------------------------------------
// lla_front
// accepts raw samples, clamps them and rescales them to a level of 0 to 100
// with a restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module lla_front
    import lla_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  lla_cfg_t            cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [SAMPLE_W-1:0] s_raw_sample,
    output logic                push_valid,
    output logic [LEVEL_W-1:0]  push_level,
    input  lla_q_status_t       q_status
);

    localparam int NUM_W  = SAMPLE_W + LEVEL_W;
    localparam int STEP_W = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {F_IDLE, F_MUL, F_DIV, F_PUSH} f_state_t;

    f_state_t            state_reg;
    logic [SAMPLE_W-1:0] off_reg;
    logic [SAMPLE_W-1:0] span_reg;
    logic                empty_reg;
    logic [NUM_W-1:0]    rem_reg;
    logic [LEVEL_W-1:0]  quo_reg;
    logic [STEP_W-1:0]   step_reg;

    logic                span_empty;
    logic [SAMPLE_W-1:0] clamped;
    logic [NUM_W-1:0]    div_cand;

    // clamp to the limits, empty span gives level zero
    always_comb begin
        span_empty = (cfg.high_limit <= cfg.low_limit);
        if (s_raw_sample < cfg.low_limit) begin
            clamped = cfg.low_limit;
        end else if (s_raw_sample > cfg.high_limit) begin
            clamped = cfg.high_limit;
        end else begin
            clamped = s_raw_sample;
        end
    end

    // divisor shifted to the current quotient bit
    assign div_cand = NUM_W'(span_reg) << step_reg;

    assign s_ready    = (state_reg == F_IDLE);
    assign push_valid = (state_reg == F_PUSH);
    assign push_level = quo_reg;

    // sequencer: capture, scale by 100, divide unless the span is empty, hand over
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            case (state_reg)
                F_IDLE: begin
                    if (s_valid) begin
                        off_reg   <= clamped - cfg.low_limit;
                        span_reg  <= cfg.high_limit - cfg.low_limit;
                        empty_reg <= span_empty;
                        state_reg <= F_MUL;
                    end
                end
                F_MUL: begin
                    rem_reg  <= NUM_W'(off_reg) * NUM_W'(LEVEL_MAX);
                    quo_reg  <= '0;
                    step_reg <= STEP_W'(DIV_STEPS - 1);
                    state_reg <= empty_reg ? F_PUSH : F_DIV;
                end
                F_DIV: begin
                    if (rem_reg >= div_cand) begin
                        rem_reg           <= rem_reg - div_cand;
                        quo_reg[step_reg] <= 1'b1;
                    end
                    if (step_reg == '0) begin
                        state_reg <= F_PUSH;
                    end else begin
                        step_reg <= step_reg - 1'b1;
                    end
                end
                F_PUSH: begin
                    if (!q_status.full) begin
                        state_reg <= F_IDLE;
                    end
                end
                default: begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

[hdl/lla_queue.sv]
// ---------------------------------------------------------------------------
// lla_queue
// short fifo of levels between the front end and the averaging back end
// ---------------------------------------------------------------------------
module lla_queue
    import lla_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  logic [LEVEL_W-1:0] push_level,
    input  logic               pop,
    output logic [LEVEL_W-1:0] pop_level,
    output lla_q_status_t      status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [LEVEL_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    logic do_push;
    logic do_pop;

    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_level    = entry_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_level;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

[hdl/lla_back.sv]
// ---------------------------------------------------------------------------
// lla_back
// writes levels into the ring, keeps a running sum, decides on a report and
// forms the mean by multiplying the sum with the reciprocal of the ring depth
// ---------------------------------------------------------------------------
module lla_back
    import lla_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  lla_cfg_t           cfg,
    input  lla_q_status_t      q_status,
    input  logic [LEVEL_W-1:0] pop_level,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [LEVEL_W-1:0] m_light_level
);

    localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int SUM_W  = $clog2(LEVEL_MAX * RING_DEPTH + 1);

    // reciprocal of the ring depth, exact for every sum below 2**SUM_W
    localparam int DIV_SHIFT = SUM_W + $clog2(RING_DEPTH);
    localparam int DIV_MULT  = ((1 << DIV_SHIFT) + RING_DEPTH - 1) / RING_DEPTH;
    localparam int MULT_W    = SUM_W + 2;
    localparam int PROD_W    = SUM_W + MULT_W;

    typedef enum logic [2:0] {B_IDLE, B_UPDATE, B_DIV, B_OUT} b_state_t;

    b_state_t           state_reg;
    logic [LEVEL_W-1:0] ring_mem [RING_DEPTH];
    logic [LEVEL_W-1:0] rd_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic               wrapped_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [LEVEL_W-1:0] last_avg_reg;
    logic               avg_valid_reg;
    logic               m_valid_reg;

    logic [LEVEL_W-1:0] old_level;
    logic [SUM_W-1:0]   sum_next;
    logic [LEVEL_W-1:0] diff;
    logic               report;
    logic [PROD_W-1:0]  mean_prod;
    logic               ring_we;

    // slot never written since reset reads as zero
    always_comb begin
        old_level = wrapped_reg ? rd_reg : '0;
        sum_next  = sum_reg + SUM_W'(level_reg) - SUM_W'(old_level);
        diff      = (level_reg > last_avg_reg) ? (level_reg - last_avg_reg)
                                               : (last_avg_reg - level_reg);
        report    = !avg_valid_reg || (diff > cfg.change_threshold);
        mean_prod = PROD_W'(sum_reg) * PROD_W'(MULT_W'(DIV_MULT));
    end

    assign pop           = (state_reg == B_IDLE) && !q_status.empty;
    assign ring_we       = (state_reg == B_UPDATE);
    assign m_valid       = m_valid_reg;
    assign m_light_level = last_avg_reg;

    // ring memory, registered read at the current slot
    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[slot_reg] <= level_reg;
        end
        rd_reg <= ring_mem[slot_reg];
    end

    // sequencer: fetch, update ring and sum, and on a report take the mean and present result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            slot_reg      <= '0;
            wrapped_reg   <= 1'b0;
            sum_reg       <= '0;
            last_avg_reg  <= '0;
            avg_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            case (state_reg)
                B_IDLE: begin
                    if (!q_status.empty) begin
                        level_reg <= pop_level;
                        state_reg <= B_UPDATE;
                    end
                end
                B_UPDATE: begin
                    sum_reg <= sum_next;
                    if (slot_reg == SLOT_W'(RING_DEPTH - 1)) begin
                        slot_reg    <= '0;
                        wrapped_reg <= 1'b1;
                    end else begin
                        slot_reg <= slot_reg + 1'b1;
                    end
                    state_reg <= report ? B_DIV : B_IDLE;
                end
                B_DIV: begin
                    // truncated mean from the updated sum
                    last_avg_reg  <= mean_prod[DIV_SHIFT +: LEVEL_W];
                    avg_valid_reg <= 1'b1;
                    m_valid_reg   <= 1'b1;
                    state_reg     <= B_OUT;
                end
                B_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= B_IDLE;
                    end
                end
                default: begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule
